### src/stftp_pkg.sv
// Shared constants, coefficient tables and interface types for the STFT power block.
package stftp_pkg;

  localparam int WINDOW = 64;
  localparam int WM1    = WINDOW - 1;
  localparam int AW     = $clog2(WINDOW);
  localparam int BINS   = WINDOW / 2;
  localparam int SW     = 16;
  localparam int TW     = 17;
  localparam int AccW   = 40;
  localparam int RW     = 24;
  localparam int PW     = 48;
  localparam int DW     = 40;
  localparam int CntW   = 32;
  localparam int HopW   = 7;
  localparam int HW     = PW / 2;
  localparam int RSH    = 82;

  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint C054_Q30    = 64'sd579820585;
  localparam longint C046_Q30    = 64'sd493921239;

  typedef enum logic {OP_SAMPLE = 1'b0, OP_FLUSH = 1'b1} op_t;

  typedef logic signed [TW-1:0] trig_tab_t [WINDOW];
  typedef logic [SW-1:0] win_tab_t [WINDOW];

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          start;
    logic [AW-1:0] base;
    logic [AW:0]   valid;
    logic          next;
  } core_cmd_t;

  typedef struct packed {
    logic          p_rdy;
    logic [AW-1:0] k;
    logic          last;
    logic [PW-1:0] p;
  } core_sts_t;

  function automatic longint cos_q30(logic [31:0] phase);
    logic [1:0] q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint c;
    q = phase[31:30];
    r = {34'd0, phase[29:0]};
    if (q[0]) begin
      r = ONE_Q30 - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 90;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 56;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 12;
    c  = ONE_Q30 - longint'(((x2 * t) >> 30) / 2);
    return (q == 2'd1 || q == 2'd2) ? -c : c;
  endfunction

  function automatic logic signed [TW-1:0] q30_to_q15(longint c);
    longint b;
    b = c + ONE_Q30;
    if (b < 0) begin
      b = 0;
    end
    return TW'(((b + 16384) >>> 15) - 32768);
  endfunction

  function automatic longint hamming_raw(int i);
    longint c;
    longint p;
    c = cos_q30(32'(((longint'(i % WM1)) << 32) / WM1));
    p = C046_Q30 * c;
    return C054_Q30 - (p >>> 30);
  endfunction

  function automatic longint gen_wmax();
    longint mx;
    mx = 1;
    for (int i = 0; i < WINDOW; i++) begin
      if (hamming_raw(i) > mx) begin
        mx = hamming_raw(i);
      end
    end
    return mx;
  endfunction

  localparam longint WMAX = gen_wmax();

  function automatic win_tab_t gen_win();
    win_tab_t w;
    for (int i = 0; i < WINDOW; i++) begin
      w[i] = SW'((hamming_raw(i) * 32768 + WMAX / 2) / WMAX);
    end
    return w;
  endfunction

  function automatic trig_tab_t gen_cos();
    trig_tab_t t;
    for (int i = 0; i < WINDOW; i++) begin
      t[i] = q30_to_q15(cos_q30(32'((longint'(i) << 32) / WINDOW)));
    end
    return t;
  endfunction

  function automatic trig_tab_t gen_sin();
    trig_tab_t t;
    for (int i = 0; i < WINDOW; i++) begin
      t[i] = q30_to_q15(cos_q30(32'((longint'(i) << 32) / WINDOW) - 32'h4000_0000));
    end
    return t;
  endfunction

  localparam win_tab_t  WIN_TAB = gen_win();
  localparam trig_tab_t COS_TAB = gen_cos();
  localparam trig_tab_t SIN_TAB = gen_sin();

  function automatic longint gen_wsum();
    longint s;
    s = 0;
    for (int i = 0; i < WINDOW; i++) begin
      s = s + longint'(WIN_TAB[i]) * longint'(WIN_TAB[i]);
    end
    return (s == 0) ? 1 : s;
  endfunction

  localparam logic [DW-1:0] WSUM = DW'(gen_wsum());

  // floor(2^RSH / WSUM): the quotient estimate is low by at most one
  localparam logic [PW-1:0] WRECIP = PW'((128'd1 << RSH) / 128'(WSUM));

endpackage

### src/stftp_core.sv
// Sample store, windowing and per-bin DFT accumulation with squared magnitude.
module stftp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  stftp_pkg::core_cmd_t cmd,
  output stftp_pkg::core_sts_t sts
);
  import stftp_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_WIN, C_BIN, C_RND, C_SQ1, C_SQ2, C_DONE} cstate_t;

  cstate_t                state;
  logic [AW:0]            cnt;
  logic                   act;
  logic [AW-1:0]          base;
  logic [AW:0]            valid;
  logic [AW-1:0]          rd_i;
  logic [AW-1:0]          k;
  logic [AW-1:0]          m;
  logic [AW-1:0]          m_d;
  logic signed [SW-1:0]   sd;
  logic signed [TW-1:0]   tq;
  logic signed [AccW-1:0] re;
  logic signed [AccW-1:0] im;
  logic signed [RW-1:0]   r15;
  logic signed [RW-1:0]   i15;
  logic [PW-1:0]          sq;
  logic [PW-1:0]          p;

  logic signed [SW-1:0]   store [WINDOW];
  logic signed [TW-1:0]   work  [WINDOW];

  logic [AW-1:0]          s_raddr;
  logic signed [TW-1:0]   x;
  logic signed [2*TW-1:0] wprod;
  logic signed [2*TW-1:0] twv;
  logic signed [2*TW-1:0] cprod;
  logic signed [2*TW-1:0] sprod;
  logic signed [AccW-1:0] re_rnd;
  logic signed [AccW-1:0] im_rnd;

  always_comb begin
    s_raddr = base + cnt[AW-1:0];
    x       = ({1'b0, rd_i} < valid) ? TW'(sd) : '0;
    wprod   = x * $signed({1'b0, WIN_TAB[rd_i]});
    twv     = (wprod + (2*TW)'(16384)) >>> 15;
    cprod   = tq * COS_TAB[m_d];
    sprod   = tq * SIN_TAB[m_d];
    re_rnd  = (re + AccW'(16384)) >>> 15;
    im_rnd  = (im + AccW'(16384)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[cmd.wr_addr] <= cmd.wr_data;
    end
    sd <= store[s_raddr];
    if (state == C_WIN && act) begin
      work[rd_i] <= twv[TW-1:0];
    end
    tq <= work[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
      act   <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd.start) begin
            base  <= cmd.base;
            valid <= cmd.valid;
            cnt   <= '0;
            act   <= 1'b0;
            k     <= '0;
            state <= C_WIN;
          end
        end
        C_WIN: begin
          act  <= ~cnt[AW];
          rd_i <= cnt[AW-1:0];
          if (!cnt[AW]) begin
            cnt <= cnt + 1'b1;
          end else if (!act) begin
            cnt   <= '0;
            m     <= '0;
            re    <= '0;
            im    <= '0;
            state <= C_BIN;
          end
        end
        C_BIN: begin
          act <= ~cnt[AW];
          m_d <= m;
          if (act) begin
            re <= re + AccW'(cprod);
            im <= im - AccW'(sprod);
          end
          if (!cnt[AW]) begin
            cnt <= cnt + 1'b1;
            m   <= m + k;
          end else if (!act) begin
            state <= C_RND;
          end
        end
        C_RND: begin
          r15   <= re_rnd[RW-1:0];
          i15   <= im_rnd[RW-1:0];
          state <= C_SQ1;
        end
        C_SQ1: begin
          sq    <= PW'(r15 * r15);
          state <= C_SQ2;
        end
        C_SQ2: begin
          p     <= sq + PW'(i15 * i15);
          state <= C_DONE;
        end
        C_DONE: begin
          if (cmd.next) begin
            if (k == AW'(BINS)) begin
              state <= C_IDLE;
            end else begin
              k     <= k + 1'b1;
              cnt   <= '0;
              act   <= 1'b0;
              m     <= '0;
              re    <= '0;
              im    <= '0;
              state <= C_BIN;
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign sts.p_rdy = (state == C_DONE);
  assign sts.k     = k;
  assign sts.last  = (k == AW'(BINS));
  assign sts.p     = p;

endmodule

### src/stftp_div.sv
// Reciprocal-multiply unit that scales a bin power by the window energy.
module stftp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [stftp_pkg::PW-1:0]  p,
  output logic                      done,
  output logic [stftp_pkg::PW-1:0]  power
);
  import stftp_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_MULR, D_MULS, D_FIX} dstate_t;

  dstate_t         state;
  logic [1:0]      step;
  logic [PW-1:0]   pin;
  logic [PW-1:0]   q0;
  logic [2*PW-1:0] acc;

  logic [HW-1:0]   ma;
  logic [HW-1:0]   mb;
  logic [2*HW-1:0] mprod;
  logic [2*PW-1:0] addend;
  logic [2*PW-1:0] acc_sum;
  logic [PW-1:0]   rem;

  always_comb begin
    if (state == D_MULS) begin
      ma = step[1] ? q0[PW-1:HW] : q0[HW-1:0];
      mb = step[0] ? HW'(WSUM[DW-1:HW]) : WSUM[HW-1:0];
    end else begin
      ma = step[1] ? pin[PW-1:HW] : pin[HW-1:0];
      mb = step[0] ? WRECIP[PW-1:HW] : WRECIP[HW-1:0];
    end
    mprod = ma * mb;
    case (step)
      2'd0:    addend = {{PW{1'b0}}, mprod};
      2'd3:    addend = {mprod, {PW{1'b0}}};
      default: addend = {{HW{1'b0}}, mprod, {HW{1'b0}}};
    endcase
    acc_sum = acc + addend;
    rem     = {pin[PW-33:0], 32'd0} - acc[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            pin   <= p;
            acc   <= '0;
            step  <= '0;
            state <= D_MULR;
          end
        end
        D_MULR: begin
          step <= step + 1'b1;
          if (step == 2'd3) begin
            q0    <= PW'(acc_sum >> (RSH - 32));
            acc   <= '0;
            state <= D_MULS;
          end else begin
            acc <= acc_sum;
          end
        end
        D_MULS: begin
          acc  <= acc_sum;
          step <= step + 1'b1;
          if (step == 2'd2) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          power <= (rem >= PW'(WSUM)) ? q0 + 1'b1 : q0;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### src/hamming_stft_power_spectrum.sv
// Top level: stream control, frame sequencing and result register.
// Sample transfer without a frame: 1 cycle, next transfer the cycle after.
// Completed frame: windowing, then per bin MAC accumulation, rounding and squaring,
// scaling and handoff, for all 33 bins before the next transfer is taken; output
// stalls in the handoff lengthen the frame.
// Synchronous active-high reset: hop 32, empty stream; stores hold no reset.
module hamming_stft_power_spectrum (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample
  input  logic [0:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // bin_index[5:0], power[53:6], zero[55:54]
  output logic        m_tlast,   // last_bin
  output logic [0:0]  m_tuser,   // no_frame
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata  // hop length
);
  import stftp_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_CORE, T_DIV, T_PUT} tstate_t;

  tstate_t         state;
  logic [HopW-1:0] hop_len;
  logic [CntW-1:0] count;
  logic [CntW-1:0] fs;
  logic            flushing;
  logic            nof;

  core_cmd_t       cmd;
  core_sts_t       sts;
  logic            div_done;
  logic [PW-1:0]   power;

  logic            acc;
  logic            free;
  logic [HopW-1:0] hop_eff;
  logic [CntW-1:0] sbase;
  logic [CntW-1:0] sfs;
  logic [CntW-1:0] scount_next;
  logic [CntW-1:0] d;
  logic            s_frame;
  logic            f_frame;

  always_comb begin
    acc         = s_tvalid && s_tready;
    free        = !m_tvalid || m_tready;
    hop_eff     = (hop_len == '0) ? HopW'(1) :
                  (hop_len > HopW'(WINDOW)) ? HopW'(WINDOW) : hop_len;
    sbase       = flushing ? '0 : count;
    sfs         = flushing ? '0 : fs;
    scount_next = sbase + 1'b1;
    s_frame     = (scount_next - sfs) == CntW'(WINDOW);
    d           = count - fs;
    f_frame     = (d >= CntW'(1)) && (d < CntW'(WINDOW));

    cmd.wr_en   = acc && (s_tuser == OP_SAMPLE);
    cmd.wr_addr = sbase[AW-1:0];
    cmd.wr_data = s_tdata;
    cmd.start   = acc && ((s_tuser == OP_SAMPLE) ? s_frame : f_frame);
    cmd.base    = (s_tuser == OP_SAMPLE) ? sfs[AW-1:0] : fs[AW-1:0];
    cmd.valid   = (s_tuser == OP_SAMPLE) ? (AW+1)'(WINDOW) : d[AW:0];
    cmd.next    = (state == T_PUT) && free && !nof;
  end

  assign s_tready = (state == T_IDLE);

  stftp_core u_core (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  stftp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start ((state == T_CORE) && sts.p_rdy),
    .p     (sts.p),
    .done  (div_done),
    .power (power)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      hop_len  <= HopW'(32);
      count    <= '0;
      fs       <= '0;
      flushing <= 1'b0;
      nof      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        hop_len <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != T_PUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (acc) begin
            if (s_tuser == OP_SAMPLE) begin
              count    <= scount_next;
              flushing <= 1'b0;
              fs       <= s_frame ? sfs + CntW'(hop_eff) : sfs;
              if (s_frame) begin
                state <= T_CORE;
              end
            end else if (f_frame) begin
              flushing <= 1'b1;
              fs       <= fs + CntW'(hop_eff);
              state    <= T_CORE;
            end else begin
              count    <= '0;
              fs       <= '0;
              flushing <= 1'b0;
              nof      <= 1'b1;
              state    <= T_PUT;
            end
          end
        end
        T_CORE: begin
          if (sts.p_rdy) begin
            state <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_done) begin
            state <= T_PUT;
          end
        end
        T_PUT: begin
          if (free) begin
            m_tvalid <= 1'b1;
            if (nof) begin
              m_tdata <= '0;
              m_tlast <= 1'b0;
              m_tuser <= 1'b1;
              nof     <= 1'b0;
              state   <= T_IDLE;
            end else begin
              m_tdata <= {2'b00, power, sts.k};
              m_tlast <= sts.last;
              m_tuser <= 1'b0;
              state   <= sts.last ? T_IDLE : T_CORE;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

### sim/hamming_stft_power_spectrum_tb.sv
// Testbench for hamming_stft_power_spectrum: checks every bin power against an internal predictor.
`timescale 1ns / 1ps
module hamming_stft_power_spectrum_tb;
  import stftp_pkg::*;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint HAM_A = 64'sd579820585;
  localparam longint HAM_B = 64'sd493921239;
  localparam longint unsigned POWER_SAT = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    op_t         op;
    logic [15:0] smp;
  } stim_t;

  typedef struct {
    logic [5:0]  bin;
    logic [47:0] pwr;
    logic        last;
    logic        nf;
  } bin_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  stim_t       pend_q[$];
  bin_t        bins_q[$];
  logic        took;
  int          errors;
  int unsigned cyc;

  longint      cos15[64];
  longint      sin15[64];
  longint      win[64];
  longint unsigned energy;
  logic [6:0]  hop_reg;
  longint      store[64];
  longint      work[64];
  logic [31:0] pos;
  logic [31:0] fstart;
  logic        flushing;

  hamming_stft_power_spectrum dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint cos_q30(logic [31:0] phase);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint c;
    r = {34'd0, phase[29:0]};
    if (phase[30]) r = Q30_ONE - r;
    x = (r * Q30_HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 90;
    t = Q30_ONE - ((x2 * t) >> 30) / 56;
    t = Q30_ONE - ((x2 * t) >> 30) / 30;
    t = Q30_ONE - ((x2 * t) >> 30) / 12;
    c = longint'(Q30_ONE) - longint'(((x2 * t) >> 30) / 2);
    return (phase[31:30] == 2'd1 || phase[31:30] == 2'd2) ? -c : c;
  endfunction

  function automatic longint to_q15(longint c);
    longint b;
    b = c + longint'(Q30_ONE);
    if (b < 0) b = 0;
    return ((b + 16384) >>> 15) - 32768;
  endfunction

  function automatic logic [31:0] angle(longint num, longint den);
    return 32'(((num % den) << 32) / den);
  endfunction

  task automatic build_tables();
    longint raw[64];
    longint mx;
    logic [31:0] ph;
    mx = 1;
    for (int i = 0; i < 64; i++) begin
      ph = angle(i, 64);
      cos15[i] = to_q15(cos_q30(ph));
      sin15[i] = to_q15(cos_q30(ph - 32'h4000_0000));
      raw[i] = HAM_A - ((HAM_B * cos_q30(angle(i, 63))) >>> 30);
      if (raw[i] > mx) mx = raw[i];
    end
    energy = 0;
    for (int i = 0; i < 64; i++) begin
      win[i] = (raw[i] * 32768 + mx / 2) / mx;
      energy += longint'(win[i] * win[i]);
    end
    if (energy == 0) energy = 1;
  endtask

  function automatic logic [31:0] hop_eff();
    if (hop_reg == 0) return 1;
    if (hop_reg > 64) return 64;
    return 32'(hop_reg);
  endfunction

  function automatic logic [47:0] scaled(longint unsigned p);
    longint unsigned q;
    longint unsigned r;
    q = p / energy;
    r = p % energy;
    for (int b = 0; b < 32; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= energy) begin
        r = r - energy;
        q = q | 1;
      end
    end
    return (q > POWER_SAT) ? 48'hFFFF_FFFF_FFFF : q[47:0];
  endfunction

  task automatic spectrum_frame(logic [31:0] valid);
    longint re;
    longint im;
    longint r15;
    longint i15;
    longint x;
    bin_t b;
    for (int i = 0; i < 64; i++) begin
      x = (i < valid) ? store[(fstart + i) & 63] : 0;
      work[i] = (x * win[i] + 16384) >>> 15;
    end
    for (int k = 0; k <= 32; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < 64; n++) begin
        re += work[n] * cos15[(k * n) % 64];
        im -= work[n] * sin15[(k * n) % 64];
      end
      r15 = (re + 16384) >>> 15;
      i15 = (im + 16384) >>> 15;
      b.bin = 6'(k);
      b.pwr = scaled(longint'(r15 * r15 + i15 * i15));
      b.last = (k == 32);
      b.nf = 1'b0;
      bins_q.push_back(b);
    end
    fstart = fstart + hop_eff();
  endtask

  task automatic predict_spectrum(op_t op, logic [15:0] smp);
    logic [31:0] d;
    bin_t b;
    if (op == OP_SAMPLE) begin
      if (flushing) begin
        pos = 0;
        fstart = 0;
        flushing = 1'b0;
      end
      store[pos & 63] = longint'(signed'(smp));
      pos = pos + 1;
      if (pos - fstart == 64) spectrum_frame(64);
    end else begin
      d = pos - fstart;
      flushing = 1'b1;
      if (d >= 1 && d < 64) begin
        spectrum_frame(d);
      end else begin
        b.bin = 0;
        b.pwr = 0;
        b.last = 1'b0;
        b.nf = 1'b1;
        bins_q.push_back(b);
        pos = 0;
        fstart = 0;
        flushing = 1'b0;
      end
    end
  endtask

  function automatic logic [1:0] idle_mode();
    return 2'((cyc / 4000) % 4);
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    took <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) predict_spectrum(op_t'(s_tuser[0]), s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (bins_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer bin %0d power %0d last %0b no_frame %0b",
                 $time, m_tdata[5:0], m_tdata[53:6], m_tlast, m_tuser[0]);
      end else if (m_tdata[5:0] !== bins_q[0].bin || m_tdata[53:6] !== bins_q[0].pwr ||
                   m_tlast !== bins_q[0].last || m_tuser[0] !== bins_q[0].nf ||
                   m_tdata[55:54] !== 2'b00) begin
        errors++;
        $display("%0t mismatch exp bin %0d power %0d last %0b no_frame %0b", $time,
                 bins_q[0].bin, bins_q[0].pwr, bins_q[0].last, bins_q[0].nf);
        $display("%0t          got bin %0d power %0d last %0b no_frame %0b pad %0b", $time,
                 m_tdata[5:0], m_tdata[53:6], m_tlast, m_tuser[0], m_tdata[55:54]);
        void'(bins_q.pop_front());
      end else begin
        void'(bins_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    stim_t it;
    if (!rst) begin
      if (!s_tvalid || took) begin
        if (pend_q.size() > 0 &&
            !((idle_mode() == 1 && $urandom_range(0, 99) < 53) ||
              (idle_mode() == 3 && $urandom_range(0, 99) < 9))) begin
          it = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.smp;
          s_tuser <= it.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !((idle_mode() == 2 && $urandom_range(0, 99) < 53) ||
                    (idle_mode() == 3 && $urandom_range(0, 99) < 9));
    end
  end

  task automatic push_sample(logic [15:0] v);
    stim_t it;
    it.op = OP_SAMPLE;
    it.smp = v;
    pend_q.push_back(it);
  endtask

  task automatic push_flush();
    stim_t it;
    it.op = OP_FLUSH;
    it.smp = 16'($urandom);
    pend_q.push_back(it);
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || s_tvalid || bins_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_hop(logic [6:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hop_reg = v;
  endtask

  task automatic random_items(int n, int flush_pct);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < flush_pct) begin
        repeat ($urandom_range(1, 3)) push_flush();
        k += 2;
      end else begin
        case ($urandom_range(0, 9))
          0: push_sample(16'h7FFF);
          1: push_sample(16'h8000);
          default: push_sample(16'($urandom));
        endcase
        k++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    took = 1'b0;
    errors = 0;
    cyc = 0;
    hop_reg = 7'd32;
    pos = 0;
    fstart = 0;
    flushing = 1'b0;
    for (int i = 0; i < 64; i++) store[i] = 0;
    build_tables();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_flush();
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_flush();
    push_flush();
    push_flush();
    push_sample(16'h1234);
    push_sample(16'hC000);
    push_flush();
    push_sample(16'h4000);
    push_sample(16'h8000);
    push_flush();
    push_flush();
    drain();

    set_hop(7'd64);
    random_items(70, 2);
    set_hop(7'd127);
    for (int i = 0; i < 64; i++) push_sample(i[0] ? 16'h8000 : 16'h7FFF);
    push_flush();
    push_flush();
    set_hop(7'd17);
    random_items(70, 4);
    push_flush();
    push_flush();
    set_hop(7'd5);
    random_items(20, 5);
    set_hop(7'd0);
    random_items(66, 0);
    push_flush();
    set_hop(7'd1);
    random_items(8, 0);
    push_flush();
    push_flush();
    set_hop(7'd32);
    random_items(20, 10);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
